@@ hdl/stepper_motion_controller_assert.svh @@
// assertion macros shared by the stepper controller modules
`ifndef STEPPER_MOTION_CONTROLLER_ASSERT_SVH
`define STEPPER_MOTION_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

`define SMC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SMC_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define SMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/smc_pkg.sv @@
`default_nettype none

package smc_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_MOVE    = 2'd1,
    OP_HOME    = 2'd2,
    OP_MEASURE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_MOVE    = 2'd1,
    MODE_HOME    = 2'd2,
    MODE_MEASURE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    HS_SEEK  = 2'd0,
    HS_BACK  = 2'd1,
    HS_FINAL = 2'd2
  } home_stage_t;

  localparam logic [15:0] WAIT_TICKS_RESET = 16'd3;
  localparam logic [23:0] MEASURED_MAX     = 24'hFFFFFF;

  typedef struct packed {
    op_t                operation;
    logic signed [23:0] move_delta;
    logic               direction;
    logic               start_switch;
    logic               end_switch;
  } smc_in_t;

  typedef struct packed {
    logic [3:0]  coils;
    logic        busy_res;
    logic        done_res;
    logic        rejected;
    logic [23:0] measured_steps;
  } smc_out_t;

endpackage

`default_nettype wire

@@ hdl/smc_core.sv @@
`default_nettype none

`include "stepper_motion_controller_assert.svh"

module smc_core #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire smc_pkg::smc_in_t in_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [15:0]      cfg_wr_data,
  output smc_pkg::smc_out_t     res
);
  import smc_pkg::*;

  localparam int MW = (COUNT_BITS > 24) ? COUNT_BITS : 24;
  localparam logic [MW-1:0] COUNT_MAX_W = MW'({COUNT_BITS{1'b1}});
  localparam logic [MW-1:0] OUT_MAX_W   = MW'(MEASURED_MAX);

  logic [1:0]            phase_r, phase_nxt;
  mode_t                 mode_r, mode_nxt;
  home_stage_t           stage_r, stage_nxt;
  logic [COUNT_BITS-1:0] steps_r, steps_nxt;
  logic [15:0]           wait_r, wait_nxt;
  logic                  dir_r, dir_nxt;
  logic [COUNT_BITS-1:0] tally_r, tally_nxt;
  logic [15:0]           wait_ticks_r;

  logic                  done, rej;
  logic                  do_step, step_dir;
  logic                  both_rel;
  logic [23:0]           raw_delta, mag;
  logic [MW-1:0]         mag_w, tally_w;

  assign raw_delta = in_data.move_delta;
  assign mag       = raw_delta[23] ? (~raw_delta + 24'd1) : raw_delta;
  assign mag_w     = MW'(mag);
  assign both_rel  = in_data.start_switch && in_data.end_switch;

  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    stage_nxt = stage_r;
    steps_nxt = steps_r;
    wait_nxt  = wait_r;
    dir_nxt   = dir_r;
    tally_nxt = tally_r;
    done      = 1'b0;
    rej       = 1'b0;
    do_step   = 1'b0;
    step_dir  = dir_r;

    // command intake, only while idle
    if (in_data.operation != OP_TICK) begin
      if (mode_r != MODE_IDLE) begin
        rej = 1'b1;
      end else begin
        wait_nxt = 16'd0;
        unique case (in_data.operation)
          OP_MOVE: begin
            dir_nxt   = !raw_delta[23];
            steps_nxt = (mag_w > COUNT_MAX_W) ? COUNT_MAX_W[COUNT_BITS-1:0]
                                              : mag_w[COUNT_BITS-1:0];
            mode_nxt  = MODE_MOVE;
          end
          OP_HOME: begin
            dir_nxt   = in_data.direction;
            stage_nxt = HS_SEEK;
            mode_nxt  = MODE_HOME;
          end
          OP_MEASURE: begin
            dir_nxt   = in_data.direction;
            tally_nxt = '0;
            mode_nxt  = MODE_MEASURE;
          end
          default: begin
          end
        endcase
      end
    end

    step_dir = dir_nxt;
    if (mode_nxt != MODE_IDLE) begin
      if (wait_nxt != 16'd0) begin
        wait_nxt = wait_nxt - 16'd1;
      end else begin
        unique case (mode_nxt)
          MODE_MOVE: begin
            if (steps_nxt == '0) begin
              mode_nxt = MODE_IDLE;
              done     = 1'b1;
            end else begin
              do_step   = 1'b1;
              steps_nxt = steps_nxt - COUNT_BITS'(1);
            end
          end
          MODE_HOME: begin
            unique case (stage_nxt)
              HS_SEEK: begin
                do_step = 1'b1;
                if (!both_rel) begin
                  step_dir  = !dir_nxt;
                  stage_nxt = HS_BACK;
                end
              end
              HS_BACK: begin
                do_step = 1'b1;
                if (both_rel) begin
                  stage_nxt = HS_FINAL;
                end else begin
                  step_dir = !dir_nxt;
                end
              end
              default: begin
                if (both_rel) begin
                  do_step   = 1'b1;
                  stage_nxt = HS_FINAL;
                end else begin
                  mode_nxt  = MODE_IDLE;
                  stage_nxt = HS_SEEK;
                  done      = 1'b1;
                end
              end
            endcase
          end
          MODE_MEASURE: begin
            if (in_data.end_switch) begin
              do_step = 1'b1;
              if (tally_nxt != COUNT_MAX_W[COUNT_BITS-1:0]) begin
                tally_nxt = tally_nxt + COUNT_BITS'(1);
              end
            end else begin
              mode_nxt = MODE_IDLE;
              done     = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (do_step) begin
      phase_nxt = step_dir ? (phase_r + 2'd1) : (phase_r - 2'd1);
      wait_nxt  = wait_ticks_r;
    end
  end

  assign tally_w = MW'(tally_nxt);

  always_comb begin
    res.coils          = 4'b0001 << phase_nxt;
    res.busy_res       = (mode_nxt != MODE_IDLE);
    res.done_res       = done;
    res.rejected       = rej;
    res.measured_steps = (tally_w > OUT_MAX_W) ? MEASURED_MAX : tally_w[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      mode_r  <= MODE_IDLE;
      stage_r <= HS_SEEK;
      steps_r <= '0;
      wait_r  <= 16'd0;
      dir_r   <= 1'b0;
      tally_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      stage_r <= stage_nxt;
      steps_r <= steps_nxt;
      wait_r  <= wait_nxt;
      dir_r   <= dir_nxt;
      tally_r <= tally_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks_r <= WAIT_TICKS_RESET;
    end else if (cfg_wr_en) begin
      wait_ticks_r <= cfg_wr_data;
    end
  end

  // a pending wait never moves the rotor
  `SMC_ASSERT_NEXT(a_wait_holds_phase, clk, rst_n,
    accept && mode_r != MODE_IDLE && wait_r != 16'd0, phase_r == $past(phase_r))
  // a command while busy never swaps the running operation
  `SMC_ASSERT_NEXT(a_busy_keeps_mode, clk, rst_n,
    accept && mode_r != MODE_IDLE && in_data.operation != OP_TICK,
    mode_r == $past(mode_r) || mode_r == MODE_IDLE)
  // state advances only on an accepted beat
  `SMC_ASSERT_NEXT(a_hold_without_beat, clk, rst_n,
    !accept, $stable(phase_r) && $stable(mode_r) && $stable(tally_r))

endmodule

`default_nettype wire

@@ hdl/smc_out_reg.sv @@
`default_nettype none

module smc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire smc_pkg::smc_out_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output smc_pkg::smc_out_t      out_data
);
  import smc_pkg::*;

  logic     valid_r;
  smc_out_t data_r;
  logic     load;

  // hold upstream only while a beat sits here and downstream is stalling
  assign in_stall  = valid_r && out_stall;
  assign load      = in_valid && !in_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

@@ hdl/stepper_motion_controller.sv @@
// result: each accepted input beat is registered and its result beat is offered in the next cycle
// throughput: one beat per cycle, set by the single-pass step logic feeding
// the result register; upstream is held only while a result waits downstream
// reset: synchronous active-low rst_n clears phase, mode and counters and
// loads wait_ticks_r with 3
`default_nettype none

`include "stepper_motion_controller_assert.svh"

module stepper_motion_controller #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire smc_pkg::smc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output smc_pkg::smc_out_t      out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [15:0]       cfg_wr_data
);
  import smc_pkg::*;

  smc_out_t res;
  logic     accept;

  assign accept = in_valid && !in_stall;

  smc_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .res        (res)
  );

  smc_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (res),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // a full, stalled result register must hold the input side
  `SMC_ASSERT_SAME(a_full_blocks_input, clk, rst_n,
    out_valid && out_stall, in_stall)

endmodule

`default_nettype wire
